// ===== rtl/pacls_pkg.sv =====
package pacls_pkg;

	// Field widths
	localparam int PROTO_W = 8;
	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int LEN_W   = 16;
	localparam int ACT_W   = 8;
	localparam int MODE_W  = 3;
	localparam int HASH_W  = 32;
	localparam int KEY_W   = 2 * ADDR_W + 2 * PORT_W;
	localparam int IN_W    = PROTO_W + KEY_W + LEN_W;

	// Pipeline depth: one FNV round per byte, then the worker residue
	localparam int HASH_ROUNDS = KEY_W / 8;
	localparam int RES_STAGES  = 4;
	localparam int STAGES      = HASH_ROUNDS + RES_STAGES;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

	// Action rules
	localparam logic [MODE_W-1:0] MODE_PASS   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FILTER = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HASH   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BATCH  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SIZE   = 3'd4;

	localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

	localparam logic [PORT_W-1:0] PORT_HTTP    = 16'd80;
	localparam logic [PORT_W-1:0] PORT_HTTPS   = 16'd443;
	localparam logic [PORT_W-1:0] PORT_UDP_MIN = 16'd1024;

	localparam logic [LEN_W-1:0] SIZE_LIM0 = 16'd128;
	localparam logic [LEN_W-1:0] SIZE_LIM1 = 16'd256;
	localparam logic [LEN_W-1:0] SIZE_LIM2 = 16'd512;
	localparam logic [LEN_W-1:0] SIZE_LIM3 = 16'd1024;

	localparam logic [ACT_W-1:0] ACT_PASS_MARK = 8'h80;

	// Per-item control that rides along the pipeline
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ACT_W-1:0]  act;
	} side_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             counted;
	} result_t;

endpackage

// ===== rtl/pacls_fnv_chain.sv =====
module pacls_fnv_chain (
	input  logic                                    clk,
	input  logic [pacls_pkg::HASH_ROUNDS-1:0]       en,
	input  logic [pacls_pkg::KEY_W-1:0]             key,
	input  pacls_pkg::side_t                        side_in,
	output logic [pacls_pkg::HASH_W-1:0]            hash,
	output pacls_pkg::side_t                        side_out
);
	import pacls_pkg::*;

	logic [HASH_W-1:0] hash_s [HASH_ROUNDS];
	logic [KEY_W-1:0]  key_s  [HASH_ROUNDS];
	side_t             side_s [HASH_ROUNDS];

	// One round per stage: xor the next key byte, multiply by the prime
	for (genvar r = 0; r < HASH_ROUNDS; r++) begin : g_round
		logic [HASH_W-1:0] h_prev;
		logic [KEY_W-1:0]  k_prev;
		side_t             sd_prev;
		logic [HASH_W-1:0] mixed;

		if (r == 0) begin : g_first
			assign h_prev  = FNV_BASIS;
			assign k_prev  = key;
			assign sd_prev = side_in;
		end else begin : g_next
			assign h_prev  = hash_s[r-1];
			assign k_prev  = key_s[r-1];
			assign sd_prev = side_s[r-1];
		end

		assign mixed = h_prev ^ {{(HASH_W-8){1'b0}}, k_prev[8*r +: 8]};

		always_ff @(posedge clk) begin
			if (en[r]) begin
				hash_s[r] <= mixed * FNV_PRIME;
				key_s[r]  <= k_prev;
				side_s[r] <= sd_prev;
			end
		end
	end

	assign hash     = hash_s[HASH_ROUNDS-1];
	assign side_out = side_s[HASH_ROUNDS-1];

endmodule

// ===== rtl/pacls_residue.sv =====
module pacls_residue #(
	parameter int WORKER_COUNT = 8
) (
	input  logic                                 clk,
	input  logic [pacls_pkg::RES_STAGES-1:0]     en,
	input  logic [pacls_pkg::HASH_W-1:0]         hash,
	input  pacls_pkg::side_t                     side_in,
	output pacls_pkg::result_t                   result
);
	import pacls_pkg::*;

	localparam int RW  = $clog2(WORKER_COUNT);
	localparam int PW  = 8 + RW;
	localparam int SW  = PW + 2;
	localparam longint unsigned MUL = (64'd1 << SW) / WORKER_COUNT;
	localparam logic [RW-1:0] C0 = RW'(1 % WORKER_COUNT);
	localparam logic [RW-1:0] C1 = RW'((64'd1 << 8) % WORKER_COUNT);
	localparam logic [RW-1:0] C2 = RW'((64'd1 << 16) % WORKER_COUNT);
	localparam logic [RW-1:0] C3 = RW'((64'd1 << 24) % WORKER_COUNT);
	localparam logic [SW-1:0] WDIV = SW'(WORKER_COUNT);

	logic [HASH_W-1:0] dvd;
	logic [PW-1:0]     prod_s1 [4];
	side_t             side_s1, side_s2, side_s3;
	logic [SW-1:0]     val_s2, val_s3;
	logic [SW-1:0]     quo_s3;
	logic [2*SW-1:0]   recip;
	logic [SW-1:0]     rem_raw, rem_fix;
	logic [6:0]        worker;
	logic [ACT_W-1:0]  act_d;
	result_t           res_s4;

	// Batch mode balances on the upper half of the hash
	assign dvd = (side_in.mode == MODE_BATCH) ? {16'b0, hash[31:16]} : hash;

	// Fold the 32-bit dividend into a short sum with the same residue
	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1[0] <= PW'(dvd[7:0])   * PW'(C0);
			prod_s1[1] <= PW'(dvd[15:8])  * PW'(C1);
			prod_s1[2] <= PW'(dvd[23:16]) * PW'(C2);
			prod_s1[3] <= PW'(dvd[31:24]) * PW'(C3);
			side_s1    <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			val_s2  <= SW'(prod_s1[0]) + SW'(prod_s1[1]) + SW'(prod_s1[2]) + SW'(prod_s1[3]);
			side_s2 <= side_s1;
		end
	end

	// Quotient estimate by reciprocal, at most one short
	assign recip = (2*SW)'(val_s2) * (2*SW)'(MUL);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			quo_s3  <= recip[2*SW-1:SW];
			val_s3  <= val_s2;
			side_s3 <= side_s2;
		end
	end

	always_comb begin
		rem_raw = val_s3 - SW'(quo_s3 * WDIV);
		rem_fix = (rem_raw >= WDIV) ? rem_raw - WDIV : rem_raw;
		worker  = 7'(rem_fix[RW-1:0]);
		case (side_s3.mode)
			MODE_HASH:  act_d = worker[0] ? {1'b0, worker} : (ACT_PASS_MARK | {1'b0, worker});
			MODE_BATCH: act_d = ACT_PASS_MARK | {1'b0, worker};
			default:    act_d = side_s3.act;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			res_s4.act     <= act_d;
			res_s4.counted <= (act_d != '0);
		end
	end

	assign result = res_s4;

endmodule

// ===== rtl/packet_action_classifier_top.sv =====
// Packet action classifier. Each input beat carries one packet's header
// fields; each output beat carries its action byte (tdata) and a flag that
// is set when that byte is nonzero (tuser). One beat is accepted every
// cycle unless stalled, and results come out in order after twelve FNV-1a
// rounds, one 32-bit multiply per stage, then four stages that reduce the
// hash modulo WORKER_COUNT and form the action. A stall on the output side
// backs up only as far as the pipeline is full, so empty stages keep
// taking beats. action_mode may be written only while the pipeline is empty.
module packet_action_classifier_top #(
	parameter int WORKER_COUNT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pacls_pkg::MODE_W-1:0]       cfg_wdata,   // action_mode
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// ip_protocol, source_address, dest_address, source_port, dest_port,
	// packet_length
	input  logic [pacls_pkg::IN_W-1:0]         s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pacls_pkg::ACT_W-1:0]        m_tdata,     // action_code
	output logic                               m_tuser      // counted
);
	import pacls_pkg::*;

	logic [MODE_W-1:0]  mode_q;
	logic [STAGES-1:0]  en;
	logic [STAGES-1:0]  valid_s;
	logic [PROTO_W-1:0] in_proto;
	logic [PORT_W-1:0]  in_dport;
	logic [LEN_W-1:0]   in_len;
	logic [KEY_W-1:0]   in_key;
	side_t              side_in, side_hash;
	logic [HASH_W-1:0]  hash;
	result_t            result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// A stage advances when it is empty or the next one advances
	assign en[STAGES-1] = !valid_s[STAGES-1] || m_tready;
	for (genvar i = 0; i < STAGES - 1; i++) begin : g_en
		assign en[i] = !valid_s[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) begin
				valid_s[0] <= s_tvalid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) begin
					valid_s[i] <= valid_s[i-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	assign in_proto = s_tdata[PROTO_W-1:0];
	assign in_key   = s_tdata[PROTO_W +: KEY_W];
	assign in_dport = s_tdata[PROTO_W + 2*ADDR_W + PORT_W +: PORT_W];
	assign in_len   = s_tdata[PROTO_W + KEY_W +: LEN_W];

	// Rules that need no hash are settled on entry
	always_comb begin
		side_in.mode = mode_q;
		case (mode_q)
			MODE_FILTER: begin
				if (in_proto == PROTO_TCP) begin
					side_in.act = (in_dport == PORT_HTTP || in_dport == PORT_HTTPS) ? 8'd1 : 8'd0;
				end else if (in_proto == PROTO_UDP) begin
					side_in.act = (in_dport > PORT_UDP_MIN) ? 8'd1 : 8'd0;
				end else begin
					side_in.act = 8'd0;
				end
			end
			MODE_SIZE: begin
				if (in_len < SIZE_LIM0) begin
					side_in.act = 8'd0;
				end else if (in_len < SIZE_LIM1) begin
					side_in.act = 8'd1;
				end else if (in_len < SIZE_LIM2) begin
					side_in.act = 8'd2;
				end else if (in_len < SIZE_LIM3) begin
					side_in.act = 8'd3;
				end else begin
					side_in.act = 8'd4;
				end
			end
			default: side_in.act = 8'd1;
		endcase
	end

	pacls_fnv_chain u_fnv (
		.clk      (clk),
		.en       (en[HASH_ROUNDS-1:0]),
		.key      (in_key),
		.side_in  (side_in),
		.hash     (hash),
		.side_out (side_hash)
	);

	pacls_residue #(
		.WORKER_COUNT (WORKER_COUNT)
	) u_res (
		.clk     (clk),
		.en      (en[STAGES-1:HASH_ROUNDS]),
		.hash    (hash),
		.side_in (side_hash),
		.result  (result)
	);

	assign m_tvalid = valid_s[STAGES-1];
	assign m_tdata  = result.act;
	assign m_tuser  = result.counted;

endmodule

// ===== rtl/pacls_checker.sv =====
module pacls_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [pacls_pkg::ACT_W-1:0]        m_tdata,
	input logic                               m_tuser
);
	import pacls_pkg::*;

	// The counted flag follows the action byte
	a_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata != '0)))
		else $error("counted flag disagrees with action byte");

	// A free output stage means the whole pipeline can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output side is free");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output beat changed");

	// Nothing comes out right after reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid straight out of reset");

endmodule

bind packet_action_classifier_top pacls_checker u_chk (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import pacls_pkg::*;

	localparam int          WORKERS        = 8;
	localparam int          DRAIN_CYCLES   = STAGES + 8;
	localparam int          LONG_HOLD      = 160;
	localparam int unsigned LIMIT_NS       = 10_000_000;
	localparam int          PHASES         = 16;
	localparam int          PHASE_ITEMS    = 90;

	// action_mode values with no rule of their own
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	// first member lands in the top bits, so ip_protocol ends up at bit 0
	typedef struct packed {
		logic [LEN_W-1:0]   packet_length;
		logic [PORT_W-1:0]  dest_port;
		logic [PORT_W-1:0]  source_port;
		logic [ADDR_W-1:0]  dest_address;
		logic [ADDR_W-1:0]  source_address;
		logic [PROTO_W-1:0] ip_protocol;
	} packet_t;

	class action_ledger;
		logic [MODE_W-1:0] mode;
		int unsigned       workers;
		result_t           pending[$];
		int unsigned       errors;
		int unsigned       seen;

		function new(int unsigned w);
			mode    = MODE_PASS;
			workers = w;
			errors  = 0;
			seen    = 0;
		endfunction

		function logic [HASH_W-1:0] fnv_five_tuple(packet_t p);
			logic [HASH_W-1:0] h;
			logic [KEY_W-1:0]  key;
			h   = FNV_BASIS;
			// bytes go low first: source address, dest address, source port, dest port
			key = {p.dest_port, p.source_port, p.dest_address, p.source_address};
			for (int k = 0; k < KEY_W / 8; k++) begin
				h = (h ^ {24'd0, key[8*k +: 8]}) * FNV_PRIME;
			end
			return h;
		endfunction

		function void record_packet(packet_t p);
			logic [ACT_W-1:0]  act;
			logic [HASH_W-1:0] h;
			logic [HASH_W-1:0] worker;
			logic [HASH_W-1:0] div;
			result_t           r;
			div = (workers == 0) ? 32'd1 : workers;
			case (mode)
				MODE_FILTER: begin
					act = '0;
					if (p.ip_protocol == PROTO_TCP) begin
						if (p.dest_port == PORT_HTTP || p.dest_port == PORT_HTTPS)
							act = 8'd1;
					end else if (p.ip_protocol == PROTO_UDP) begin
						if (p.dest_port > PORT_UDP_MIN)
							act = 8'd1;
					end
				end
				MODE_HASH: begin
					h      = fnv_five_tuple(p);
					worker = h % div;
					act    = worker[ACT_W-1:0];
					if (!worker[0])
						act = {1'b0, act[ACT_W-2:0]} | ACT_PASS_MARK;
				end
				MODE_BATCH: begin
					h      = fnv_five_tuple(p);
					worker = (h >> 16) % div;
					act    = worker[ACT_W-1:0] | ACT_PASS_MARK;
				end
				MODE_SIZE: begin
					if (p.packet_length < SIZE_LIM0)
						act = 8'd0;
					else if (p.packet_length < SIZE_LIM1)
						act = 8'd1;
					else if (p.packet_length < SIZE_LIM2)
						act = 8'd2;
					else if (p.packet_length < SIZE_LIM3)
						act = 8'd3;
					else
						act = 8'd4;
				end
				default: act = 8'd1;
			endcase
			r.act     = act;
			r.counted = (act != '0);
			pending.push_back(r);
		endfunction

		function void check_action(logic [ACT_W-1:0] act, logic counted);
			result_t e;
			seen++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, action_code %0h counted %0b", $time, act,
					counted);
				return;
			end
			e = pending.pop_front();
			if (act !== e.act) begin
				errors++;
				$display("%0t: action_code expected %0h actual %0h", $time, e.act, act);
			end
			if (counted !== e.counted) begin
				errors++;
				$display("%0t: counted expected %0b actual %0b", $time, e.counted, counted);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [MODE_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [ACT_W-1:0]    m_tdata;
	logic                m_tuser;

	action_ledger ledger = new(WORKERS);
	bit           long_hold_done = 1'b0;

	packet_action_classifier_top #(
		.WORKER_COUNT(WORKERS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic packet_t make_packet(logic [PROTO_W-1:0] proto, logic [ADDR_W-1:0] sa,
			logic [ADDR_W-1:0] da, logic [PORT_W-1:0] sp, logic [PORT_W-1:0] dp,
			logic [LEN_W-1:0] len);
		packet_t p;
		p.ip_protocol    = proto;
		p.source_address = sa;
		p.dest_address   = da;
		p.source_port    = sp;
		p.dest_port      = dp;
		p.packet_length  = len;
		return p;
	endfunction

	function automatic packet_t random_packet();
		packet_t p;
		int      r;
		int      lim;
		r = $urandom_range(0, 9);
		if (r < 4)
			p.ip_protocol = PROTO_TCP;
		else if (r < 7)
			p.ip_protocol = PROTO_UDP;
		else
			p.ip_protocol = PROTO_W'($urandom_range(0, 255));
		p.source_address = $urandom;
		p.dest_address   = $urandom;
		p.source_port    = PORT_W'($urandom_range(0, 65535));
		r = $urandom_range(0, 9);
		if (r < 2)
			p.dest_port = PORT_HTTP;
		else if (r < 4)
			p.dest_port = PORT_HTTPS;
		else if (r < 6)
			p.dest_port = PORT_W'($urandom_range(PORT_UDP_MIN - 4, PORT_UDP_MIN + 6));
		else
			p.dest_port = PORT_W'($urandom_range(0, 65535));
		r = $urandom_range(0, 9);
		if (r < 5) begin
			// land right at a size boundary
			lim = SIZE_LIM0 << $urandom_range(0, 3);
			p.packet_length = LEN_W'(lim - 1 + $urandom_range(0, 1));
		end else if (r < 7) begin
			p.packet_length = LEN_W'($urandom_range(0, 2047));
		end else begin
			p.packet_length = LEN_W'($urandom_range(0, 65535));
		end
		return p;
	endfunction

	task automatic send_packet(packet_t p, bit with_gaps);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		if (with_gaps) begin
			gap = pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// let the monitor log the last accepted beat before checking the queue
	task automatic wait_for_results();
		@(posedge clk);
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(logic [MODE_W-1:0] m);
		s_tvalid <= 1'b0;
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we      <= 1'b0;
		ledger.mode = m;
	endtask

	// check every beat in both directions, sampled before this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				ledger.record_packet(packet_t'(s_tdata));
			if (m_tvalid && m_tready)
				ledger.check_action(m_tdata, m_tuser);
		end
	end

	// receiver: random stalls, plus one long hold-off to back the pipeline up
	initial begin
		int run;
		int gap;
		do @(posedge clk); while (!arst_n);
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			if (!long_hold_done && ledger.seen >= 300) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [MODE_W-1:0] m;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(MODE_FILTER);
		send_packet(make_packet(PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'd1234, PORT_HTTP,
			16'd64), 1'b1);
		send_packet(make_packet(PROTO_TCP, '1, '0, '1, PORT_HTTPS, '1), 1'b1);
		send_packet(make_packet(PROTO_TCP, '0, '1, '0, PORT_HTTP + 16'd1, '0), 1'b1);
		send_packet(make_packet(PROTO_UDP, 32'hc0a80101, 32'h08080808, 16'd53, PORT_UDP_MIN,
			16'd100), 1'b1);
		send_packet(make_packet(PROTO_UDP, 32'h12345678, 32'h9abcdef0, 16'd5000,
			PORT_UDP_MIN + 16'd1, 16'd1500), 1'b1);
		send_packet(make_packet(PROTO_UDP, '0, '0, '0, 16'hffff, 16'd9000), 1'b1);
		send_packet(make_packet(8'd0, '1, '1, '1, PORT_HTTP, '1), 1'b1);
		send_packet(make_packet(8'hff, '0, '0, '0, PORT_HTTPS, '0), 1'b1);

		set_mode(MODE_SIZE);
		send_packet(make_packet(PROTO_TCP, '0, '0, '0, '0, 16'd0), 1'b0);
		send_packet(make_packet(PROTO_TCP, '0, '0, '0, '0, SIZE_LIM0 - 16'd1), 1'b0);
		send_packet(make_packet(PROTO_UDP, '0, '0, '0, '0, SIZE_LIM0), 1'b0);
		send_packet(make_packet(PROTO_UDP, '0, '0, '0, '0, SIZE_LIM1 - 16'd1), 1'b0);
		send_packet(make_packet(8'd1, '1, '1, '1, '1, SIZE_LIM1), 1'b0);
		send_packet(make_packet(8'd1, '1, '1, '1, '1, SIZE_LIM2 - 16'd1), 1'b0);
		send_packet(make_packet(8'd2, '0, '0, '0, '0, SIZE_LIM2), 1'b0);
		send_packet(make_packet(8'd2, '0, '0, '0, '0, SIZE_LIM3 - 16'd1), 1'b0);
		send_packet(make_packet(8'd3, '0, '0, '0, '0, SIZE_LIM3), 1'b0);
		send_packet(make_packet(8'd3, '0, '0, '0, '0, 16'hffff), 1'b0);

		set_mode(MODE_HASH);
		send_packet(make_packet('0, '0, '0, '0, '0, '0), 1'b1);
		send_packet(make_packet('1, '1, '1, '1, '1, '1), 1'b1);

		set_mode(MODE_BATCH);
		send_packet(make_packet('0, '0, '0, '0, '0, '0), 1'b1);
		send_packet(make_packet('1, '1, '1, '1, '1, '1), 1'b1);

		// unassigned modes fall back to pass-through
		set_mode(MODE_SPARE_LO);
		send_packet(make_packet(PROTO_TCP, '0, '0, '0, '0, '0), 1'b1);
		set_mode(MODE_SPARE_HI);
		send_packet(make_packet(8'd0, '0, '0, '0, '0, '0), 1'b1);
		set_mode(MODE_PASS);
		send_packet(make_packet(8'd0, '0, '0, '0, '0, '0), 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			// walk every mode once, then favor the hashing rules
			if (ph < 8)
				m = ph[MODE_W-1:0];
			else if ($urandom_range(0, 1))
				m = $urandom_range(0, 1) ? MODE_HASH : MODE_BATCH;
			else
				m = MODE_W'($urandom_range(0, 7));
			set_mode(m);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_packet(random_packet(), (ph % 4) != 3);
		end

		s_tvalid <= 1'b0;
		wait_for_results();
		if (ledger.errors == 0 && ledger.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pacls_pkg.sv
rtl/pacls_fnv_chain.sv
rtl/pacls_residue.sv
rtl/packet_action_classifier_top.sv
rtl/pacls_checker.sv
dv/testbench.sv
